@@ rtl/core/kwm_pkg.sv @@
// ----------------------------------------------------------------------------
// kwm_pkg: shared types and constants of the k-way merge unit
// Holds the request layouts, the cell control group and the scan candidate.
// ----------------------------------------------------------------------------
package kwm_pkg;

  localparam int unsigned MAX_RUNS = 16;
  localparam int unsigned RUN_W    = 4;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned VAL_W    = 64;
  localparam int unsigned SCAN_W   = $clog2(MAX_RUNS);

  typedef struct packed {
    logic [RUN_W-1:0] run_index;
    logic [VAL_W-1:0] item_value;
    logic             run_ends;
  } in_req_t;

  typedef struct packed {
    logic [VAL_W-1:0] merged_value;
    logic [RUN_W-1:0] from_run;
    logic             finished;
  } out_req_t;

  // Scan candidate handed from cell to cell.
  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] value;
    logic [RUN_W-1:0] run;
  } cand_t;

  // Control group broadcast to every cell.
  typedef struct packed {
    logic             load;
    logic [RUN_W-1:0] load_run;
    logic [VAL_W-1:0] load_value;
    logic             load_ends;
    logic             take;
    logic [RUN_W-1:0] take_run;
    logic             clear;
  } cell_ctrl_t;

  // Status returned by each cell.
  typedef struct packed {
    logic present;
    logic exhausted;
    logic pending;
  } cell_stat_t;

endpackage

@@ rtl/core/kwm_cell.sv @@
// ----------------------------------------------------------------------------
// kwm_cell: one run slot of the merge chain
// Keeps the head of one run with its marks and forwards the smaller candidate.
// ----------------------------------------------------------------------------
module kwm_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [kwm_pkg::RUN_W-1:0] cell_idx_i,
  input  logic [kwm_pkg::CNT_W-1:0] active_runs_i,
  input  kwm_pkg::cell_ctrl_t       ctrl_i,
  input  kwm_pkg::cand_t            cand_i,
  output kwm_pkg::cand_t            cand_o,
  output kwm_pkg::cell_stat_t       stat_o
);

  logic [kwm_pkg::VAL_W-1:0] head_q, head_d;
  logic                      present_q, present_d;
  logic                      exhausted_q, exhausted_d;
  logic                      cand_valid_q;
  logic [kwm_pkg::VAL_W-1:0] cand_value_q;
  logic [kwm_pkg::RUN_W-1:0] cand_run_q;
  logic                      active;
  logic                      hit;
  logic                      own_wins;

  assign active = {1'b0, cell_idx_i} < active_runs_i;
  assign hit    = ctrl_i.load && active && !exhausted_q && (ctrl_i.load_run == cell_idx_i);

  always_comb begin
    head_d      = head_q;
    present_d   = present_q;
    exhausted_d = exhausted_q;
    if (ctrl_i.clear) begin
      present_d   = 1'b0;
      exhausted_d = 1'b0;
    end else if (ctrl_i.take && ctrl_i.take_run == cell_idx_i) begin
      present_d = 1'b0;
    end else if (hit) begin
      if (ctrl_i.load_ends) begin
        exhausted_d = 1'b1;
      end else if (!present_q) begin
        head_d    = ctrl_i.load_value;
        present_d = 1'b1;
      end
    end
  end

  // Lower runs sit upstream, so an equal value keeps the incoming candidate.
  assign own_wins = present_q && active && (!cand_i.valid || head_q < cand_i.value);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q    <= 1'b0;
      exhausted_q  <= 1'b0;
      cand_valid_q <= 1'b0;
    end else begin
      present_q    <= present_d;
      exhausted_q  <= exhausted_d;
      cand_valid_q <= cand_i.valid || own_wins;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    if (own_wins) begin
      cand_value_q <= head_q;
      cand_run_q   <= cell_idx_i;
    end else begin
      cand_value_q <= cand_i.value;
      cand_run_q   <= cand_i.run;
    end
  end

  assign cand_o.valid     = cand_valid_q;
  assign cand_o.value     = cand_value_q;
  assign cand_o.run       = cand_run_q;
  assign stat_o.present   = present_q;
  assign stat_o.exhausted = exhausted_q;
  assign stat_o.pending   = active && !present_q && !exhausted_q;

endmodule

@@ rtl/core/kway_merge_u64_unit.sv @@
// ----------------------------------------------------------------------------
// kway_merge_u64_unit: k-way merge of ascending unsigned 64-bit runs
// Row of run cells with a forwarding minimum scan and a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Write the number of runs through cfg_we_i / cfg_wdata_i while idle.
//   Send one request per run on the input channel (valid/ready), either a
//   value or an end mark. Once every active run holds a head or has ended,
//   the unit emits the smallest head and its run on the output channel; send
//   that run's next request afterwards. When all runs have ended and no head
//   is left, a finished request (zero value and run) closes the merge and
//   clears all marks; the run count is kept.
// Sequence:
//   A request passes through accept, the readiness check, then a scan
//   through the cell chain, where each cell registers the better of its
//   own head and its upstream neighbor's candidate. A request that leaves
//   a run still owing a value returns to idle after the check.
// Reset clears all marks and sets the run count to one. If the receiver
// stalls, the result waits in the output register; the next request is
// still accepted, and its own result holds at the scan end until the
// output register frees up.
// ----------------------------------------------------------------------------
module kway_merge_u64_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [kwm_pkg::CNT_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  kwm_pkg::in_req_t          in_req_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output kwm_pkg::out_req_t         out_req_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;

  localparam logic [kwm_pkg::CNT_W-1:0]  RUNS_MAX = kwm_pkg::CNT_W'(kwm_pkg::MAX_RUNS);
  localparam logic [kwm_pkg::SCAN_W-1:0] SCAN_END = kwm_pkg::SCAN_W'(kwm_pkg::MAX_RUNS - 1);

  logic [1:0]                  state_q, state_d;
  logic [kwm_pkg::SCAN_W-1:0]  scan_q, scan_d;
  logic [kwm_pkg::CNT_W-1:0]   runs_q;
  logic [kwm_pkg::CNT_W-1:0]   active_runs;
  logic                        out_valid_q, out_valid_d;
  kwm_pkg::out_req_t           out_q, out_d;
  kwm_pkg::cell_ctrl_t         ctrl;
  kwm_pkg::cand_t              chain [kwm_pkg::MAX_RUNS+1];
  kwm_pkg::cell_stat_t         stat  [kwm_pkg::MAX_RUNS];
  logic [kwm_pkg::MAX_RUNS-1:0] pending_vec;
  logic [kwm_pkg::MAX_RUNS-1:0] present_vec;
  logic [kwm_pkg::MAX_RUNS-1:0] exhausted_vec;
  logic                        in_fire;
  logic                        emit;
  kwm_pkg::cand_t              best;

  // Clamp the run count into 1..MAX_RUNS.
  always_comb begin
    if (runs_q == '0) begin
      active_runs = kwm_pkg::CNT_W'(1);
    end else if (runs_q > RUNS_MAX) begin
      active_runs = RUNS_MAX;
    end else begin
      active_runs = runs_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      runs_q <= kwm_pkg::CNT_W'(1);
    end else if (cfg_we_i) begin
      runs_q <= cfg_wdata_i;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign best       = chain[kwm_pkg::MAX_RUNS];
  // Emit once the last cell has seen every head and the output slot is free.
  assign emit       = (state_q == ST_SCAN) && (scan_q == SCAN_END) &&
                      (!out_valid_q || out_ready_i);

  always_comb begin
    ctrl.load       = in_fire;
    ctrl.load_run   = in_req_i.run_index;
    ctrl.load_value = in_req_i.item_value;
    ctrl.load_ends  = in_req_i.run_ends;
    ctrl.take       = emit && best.valid;
    ctrl.take_run   = best.run;
    ctrl.clear      = emit && !best.valid;
  end

  assign chain[0] = '0;

  for (genvar g = 0; g < kwm_pkg::MAX_RUNS; g++) begin : g_cell
    kwm_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cell_idx_i    (kwm_pkg::RUN_W'(g)),
      .active_runs_i (active_runs),
      .ctrl_i        (ctrl),
      .cand_i        (chain[g]),
      .cand_o        (chain[g+1]),
      .stat_o        (stat[g])
    );
    assign pending_vec[g]   = stat[g].pending;
    assign present_vec[g]   = stat[g].present;
    assign exhausted_vec[g] = stat[g].exhausted;
  end

  // Sequencer: accept, check readiness, scan, emit.
  always_comb begin
    state_d = state_q;
    scan_d  = scan_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (|pending_vec) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_SCAN;
          scan_d  = '0;
        end
      end
      ST_SCAN: begin
        if (scan_q != SCAN_END) begin
          scan_d = scan_q + kwm_pkg::SCAN_W'(1);
        end else if (emit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: load on emit, drop when taken.
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
      if (best.valid) begin
        out_d.merged_value = best.value;
        out_d.from_run     = best.run;
        out_d.finished     = 1'b0;
      end else begin
        out_d.merged_value = '0;
        out_d.from_run     = '0;
        out_d.finished     = 1'b1;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // A value result names an active run.
  a_run_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && best.valid |-> {1'b0, best.run} < active_runs)
    else $error("emitted run outside active runs");

  // The emitted run gives up its head.
  a_head_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && best.valid |=> !present_vec[$past(best.run)])
    else $error("head still present after emit");

  // Finish leaves every mark cleared.
  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !best.valid |=> (present_vec == '0) && (exhausted_vec == '0))
    else $error("marks not cleared after finish");

  // A scan only starts when no active run still owes a value.
  a_scan_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> pending_vec == '0)
    else $error("scan running while a run is pending");

endmodule

@@ tb/sv/tb_kway_merge_u64_unit.sv @@
// ----------------------------------------------------------------------------
// tb_kway_merge_u64_unit: self-checking bench for the k-way merge unit
// Feeds merges of random runs through the request channel, predicts every
// merged request and finish mark, and compares them with what the unit sends.
// ----------------------------------------------------------------------------
module tb_kway_merge_u64_unit;
  import kwm_pkg::*;

  localparam int unsigned ITEMS       = 1850;  // requests to feed
  localparam int unsigned SETTLE      = 2 * MAX_RUNS + 8;  // covers one scan pass
  localparam int unsigned STALL_LIMIT = 2000;  // cycles without any handshake
  localparam int unsigned REPORT_MAX  = 10;
  localparam int unsigned PLAN_DEPTH  = 40;

  logic           clk         = 1'b0;
  logic           rst_n       = 1'b0;
  logic           cfg_we      = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;
  logic           in_valid    = 1'b0;
  logic           in_ready;
  in_req_t        in_req      = '0;
  logic           out_valid;
  logic           out_ready   = 1'b0;
  out_req_t       out_req;

  kway_merge_u64_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_req_o   (out_req)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Merge predictor: its own copy of the run count, heads and marks
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]    runs_reg = CNT_W'(1);
  logic [VAL_W-1:0]    head_val [MAX_RUNS];
  logic [MAX_RUNS-1:0] head_held = '0;
  logic [MAX_RUNS-1:0] run_done  = '0;
  out_req_t            merge_expect_q[$];

  // Clamp the run count: zero acts as one, anything past the row acts as full.
  function automatic int active_runs(input logic [CNT_W-1:0] cnt);
    if (cnt == '0) return 1;
    if (cnt > MAX_RUNS) return MAX_RUNS;
    return int'(cnt);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Take one request in, then run the readiness check; queue the merged
  // request or the finish mark that the unit owes for it.
  task automatic merge_predict(input in_req_t req);
    int       n;
    int       i;
    int       best;
    logic     all_ready;
    out_req_t res;
    n = active_runs(runs_reg);
    if (int'(req.run_index) < n && !run_done[req.run_index]) begin
      if (req.run_ends) begin
        run_done[req.run_index] = 1'b1;
      end else if (!head_held[req.run_index]) begin
        head_val[req.run_index]  = req.item_value;
        head_held[req.run_index] = 1'b1;
      end
    end
    all_ready = 1'b1;
    for (i = 0; i < n; i++) begin
      if (!head_held[i] && !run_done[i]) all_ready = 1'b0;
    end
    if (all_ready) begin
      // Strict compare keeps the lower run on ties.
      best = -1;
      for (i = 0; i < n; i++) begin
        if (head_held[i] && (best < 0 || head_val[i] < head_val[best])) best = i;
      end
      if (best >= 0) begin
        res.merged_value = head_val[best];
        res.from_run     = RUN_W'(best);
        res.finished     = 1'b0;
        head_held[best]  = 1'b0;
      end else begin
        res.merged_value = '0;
        res.from_run     = '0;
        res.finished     = 1'b1;
        head_held        = '0;
        run_done         = '0;
      end
      merge_expect_q.insert(merge_expect_q.size(), res);
    end
  endtask

  // --------------------------------------------------------------------------
  // Request driver and result stall control, both at the falling edge
  // --------------------------------------------------------------------------
  in_req_t     pending_q[$];
  logic        in_took     = 1'b0;
  logic        quiet       = 1'b0;  // no gaps on either side while set
  int unsigned send_gap    = 0;
  int unsigned stall_left  = 0;
  int unsigned req_pushed  = 0;
  int unsigned req_taken   = 0;
  int unsigned idle_cycles = 0;
  int unsigned merge_errors = 0;

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk) begin : drive_requests
    if (rst_n) begin
      // Retire the request taken at the last rising edge.
      if (in_took) void'(pending_q.pop_front());
      // Hold valid and payload until the request is taken.
      if (!in_valid || in_took) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap--;
        end else if (pending_q.size() != 0) begin
          in_valid <= 1'b1;
          in_req   <= pending_q[0];
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk) begin : drive_stalls
    if (rst_n) begin
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: sample both channels and the register port at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch_channels
    out_req_t want;
    in_took <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (cfg_we) runs_reg = cfg_wdata;
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      // Check the result first: it can only stem from an earlier request.
      if (out_valid && out_ready) begin
        if (merge_expect_q.size() == 0) begin
          merge_errors++;
          if (merge_errors <= REPORT_MAX)
            $display("unexpected result: value %h run %0d finished %0b",
                     out_req.merged_value, out_req.from_run, out_req.finished);
        end else begin
          want = merge_expect_q.pop_front();
          if (out_req.merged_value !== want.merged_value ||
              out_req.from_run !== want.from_run ||
              out_req.finished !== want.finished) begin
            merge_errors++;
            if (merge_errors <= REPORT_MAX)
              $display("mismatch: expected value %h run %0d finished %0b, got %h run %0d finished %0b",
                       want.merged_value, want.from_run, want.finished,
                       out_req.merged_value, out_req.from_run, out_req.finished);
          end
        end
      end
      if (in_valid && in_ready) begin
        req_taken++;
        merge_predict(in_req);
      end
    end
  end

  // End the run if the handshakes stop for too long.
  initial begin
    while (idle_cycles < STALL_LIMIT) @(negedge clk);
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus planning: build one well-formed merge ahead of time
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]    runs_set = CNT_W'(1);  // count as last written
  logic [VAL_W-1:0]    plan_vals [MAX_RUNS][PLAN_DEPTH];
  int                  plan_len  [MAX_RUNS];
  int                  plan_pos  [MAX_RUNS];
  logic [VAL_W-1:0]    plan_head [MAX_RUNS];
  logic [MAX_RUNS-1:0] plan_held = '0;
  logic [MAX_RUNS-1:0] plan_done = '0;
  in_req_t             merge_plan_q[$];

  // Send the next value of a run, or its end mark once the run is used up.
  task automatic plan_next(input int r);
    in_req_t rq;
    rq.run_index  = RUN_W'(r);
    rq.item_value = rand64();
    if (plan_pos[r] >= plan_len[r]) begin
      rq.run_ends  = 1'b1;
      plan_done[r] = 1'b1;
    end else begin
      rq.run_ends   = 1'b0;
      rq.item_value = plan_vals[r][plan_pos[r]];
      plan_head[r]  = rq.item_value;
      plan_held[r]  = 1'b1;
      plan_pos[r]++;
    end
    merge_plan_q.insert(merge_plan_q.size(), rq);
  endtask

  // Extras slipped in while some run still owes a request, so none of them
  // can trigger an emission: an early end mark on a run that holds its last
  // head, and requests the unit must drop.
  task automatic plan_aside(input int n);
    in_req_t rq;
    int      start;
    int      r;
    int      k;
    int      pick;
    int      kind;
    rq.run_index  = '0;
    rq.item_value = rand64();
    rq.run_ends   = 1'b1;
    if ($urandom_range(0, 2) == 0) begin
      pick  = -1;
      start = $urandom_range(0, n - 1);
      for (k = 0; k < n; k++) begin
        r = (start + k) % n;
        if (pick < 0 && plan_held[r] && !plan_done[r] && plan_pos[r] >= plan_len[r])
          pick = r;
      end
      if (pick >= 0) begin
        rq.run_index    = RUN_W'(pick);
        plan_done[pick] = 1'b1;
        merge_plan_q.insert(merge_plan_q.size(), rq);
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      // Kinds: index past the active runs, value for a run holding a head,
      // anything for an ended run.
      kind  = $urandom_range(0, 2);
      pick  = -1;
      start = $urandom_range(0, n - 1);
      for (k = 0; k < n; k++) begin
        r = (start + k) % n;
        if (pick < 0 && ((kind == 1 && plan_held[r]) || (kind == 2 && plan_done[r])))
          pick = r;
      end
      if (kind == 0 && n < MAX_RUNS) pick = $urandom_range(n, MAX_RUNS - 1);
      if (pick >= 0) begin
        rq.run_index  = RUN_W'(pick);
        rq.item_value = rand64();
        rq.run_ends   = (kind == 1) ? 1'b0 : 1'($urandom_range(0, 1));
        merge_plan_q.insert(merge_plan_q.size(), rq);
      end
    end
  endtask

  // Draw the runs, open them in random order, then follow the emission
  // order: each emitted run sends its next request, an ended one gets a
  // dropped request to trigger the next check.
  task automatic build_merge(input int n);
    int          order [MAX_RUNS];
    int          len_cap;
    int          mode;
    int          r;
    int          j;
    int          k;
    int          best;
    int          swap_at;
    int          tmp;
    logic [63:0] v;
    logic        done_all;
    in_req_t     rq;
    len_cap = ($urandom_range(0, 7) == 0) ? PLAN_DEPTH : 5;
    mode    = $urandom_range(0, 3);
    for (r = 0; r < MAX_RUNS; r++) begin
      plan_len[r] = 0;
      plan_pos[r] = 0;
      order[r]    = r;
    end
    plan_held = '0;
    plan_done = '0;
    for (r = 0; r < n; r++) begin
      plan_len[r] = $urandom_range(0, len_cap);
      v = 64'($urandom_range(0, 20));
      for (j = 0; j < plan_len[r]; j++) begin
        case (mode)
          0: v = rand64();
          1: v = 64'($urandom_range(0, 7));  // dense ties across runs
          2: v = v + 64'($urandom_range(0, 4));  // ascending, ties likely
          default: begin
            case ($urandom_range(0, 4))
              0: v = '0;
              1: v = 64'd1;
              2: v = {64{1'b1}} - 64'd1;
              3: v = {64{1'b1}};
              default: v = rand64();
            endcase
          end
        endcase
        plan_vals[r][j] = v;
      end
    end
    for (r = n - 1; r > 0; r--) begin
      swap_at        = $urandom_range(0, r);
      tmp            = order[r];
      order[r]       = order[swap_at];
      order[swap_at] = tmp;
    end
    for (k = 0; k < n; k++) begin
      plan_aside(n);
      plan_next(order[k]);
    end
    done_all = 1'b0;
    while (!done_all) begin
      best = -1;
      for (r = 0; r < n; r++) begin
        if (plan_held[r] && (best < 0 || plan_head[r] < plan_head[best])) best = r;
      end
      if (best < 0) begin
        done_all  = 1'b1;
        plan_done = '0;
      end else begin
        plan_held[best] = 1'b0;
        if (plan_done[best]) begin
          rq.run_index  = RUN_W'(best);
          rq.item_value = rand64();
          rq.run_ends   = 1'($urandom_range(0, 1));
          merge_plan_q.insert(merge_plan_q.size(), rq);
        end else begin
          plan_aside(n);
          plan_next(best);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequencing helpers
  // --------------------------------------------------------------------------
  task automatic queue_req(input int idx, input logic [63:0] val, input logic ends);
    in_req_t rq;
    rq.run_index  = RUN_W'(idx);
    rq.item_value = val;
    rq.run_ends   = ends;
    pending_q.insert(pending_q.size(), rq);
    req_pushed++;
  endtask

  // Wait for every request taken and every result in; optionally let a
  // request that owes nothing finish its scan too.
  task automatic wait_idle(input logic settle);
    while (!(req_taken == req_pushed && merge_expect_q.size() == 0)) @(negedge clk);
    if (settle) repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_runs(input logic [CNT_W-1:0] cnt);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cnt;
    @(negedge clk);
    cfg_we   <= 1'b0;
    runs_set = cnt;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned phase;
    int unsigned cut;
    int unsigned k;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // One run from reset: lowest and highest value, a request past the
    // active runs, end marks with random payload.
    queue_req(0, 64'd0, 1'b0);
    queue_req(0, rand64(), 1'b1);
    queue_req(0, {64{1'b1}}, 1'b0);
    queue_req(1, rand64(), 1'b0);
    queue_req(0, rand64(), 1'b1);
    wait_idle(1'b1);

    // Three runs: tie to the lower run, value dropped while a head is held,
    // end mark while a head is held, request for an ended run.
    write_runs(CNT_W'(3));
    @(posedge clk);
    queue_req(2, 64'd5, 1'b0);
    queue_req(0, 64'd5, 1'b0);
    queue_req(1, {64{1'b1}}, 1'b0);
    queue_req(1, rand64(), 1'b1);
    queue_req(2, 64'd9, 1'b0);
    queue_req(0, rand64(), 1'b1);
    queue_req(2, rand64(), 1'b1);
    queue_req(1, rand64(), 1'b0);
    wait_idle(1'b1);

    // Lower the run count under a waiting merge: a dropped request must
    // still release the heads of the remaining runs.
    write_runs(CNT_W'(4));
    @(posedge clk);
    queue_req(0, 64'd7, 1'b0);
    queue_req(1, 64'd3, 1'b0);
    queue_req(2, {64{1'b1}}, 1'b0);
    wait_idle(1'b1);
    write_runs(CNT_W'(2));
    @(posedge clk);
    queue_req(3, rand64(), 1'b0);
    queue_req(0, rand64(), 1'b1);
    queue_req(1, rand64(), 1'b1);
    queue_req(15, rand64(), 1'b0);

    // Random merges; the first settings cover the count extremes.
    phase = 0;
    while (req_pushed < ITEMS) begin
      wait_idle(1'b1);
      case (phase)
        0: write_runs(CNT_W'(0));
        1: write_runs({CNT_W{1'b1}});
        2: write_runs(CNT_W'(MAX_RUNS));
        3: write_runs(CNT_W'(1));
        default: if ($urandom_range(0, 1) == 0) write_runs(CNT_W'($urandom_range(0, 31)));
      endcase
      build_merge(active_runs(runs_set));
      @(posedge clk);
      quiet = ($urandom_range(0, 3) == 0);
      // Every fifth merge, hold the feed midway until all results are in.
      cut = merge_plan_q.size();
      if (phase % 5 == 2 && merge_plan_q.size() > 1)
        cut = $urandom_range(1, merge_plan_q.size() - 1);
      for (k = 0; k < merge_plan_q.size(); k++) begin
        if (k == cut) begin
          wait_idle(1'b0);
          @(posedge clk);
        end
        pending_q.insert(pending_q.size(), merge_plan_q[k]);
        req_pushed++;
      end
      merge_plan_q.delete();
      phase++;
    end

    wait_idle(1'b1);
    merge_errors += merge_expect_q.size();
    if (merge_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
